FILE: sv/twa_pkg.sv
package twa_pkg;

    localparam int unsigned TIMER_W = 16;
    localparam int unsigned ADDR_W = 10;
    localparam int unsigned VOL_W = 4;
    localparam int unsigned OP_W = 3;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [15:0] WORD_PLAY_AFTER = 16'hFFF3;
    localparam logic [15:0] WORD_LOOP = 16'hFFF2;
    localparam logic [15:0] WORD_STOP = 16'hFFFE;
    localparam logic [15:0] WORD_VOLUME = 16'hFFE0;

    localparam logic [TIMER_W-1:0] START_LOW_RESET = 16'd5000;
    localparam logic [TIMER_W-1:0] HALF_BIT_RESET = 16'd200;
    localparam logic [TIMER_W-1:0] GAP_RESET = 16'd2000;

    typedef enum logic [OP_W-1:0] {
        OP_TICK = 3'd0,
        OP_PLAY = 3'd1,
        OP_PLAY_AFTER = 3'd2,
        OP_LOOP = 3'd3,
        OP_STOP = 3'd4,
        OP_VOLUME = 3'd5
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_LOW = 2'd0,
        CFG_HALF_BIT = 2'd1,
        CFG_GAP = 2'd2
    } cfg_idx_t;

    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_START = 5'b00010,
        PH_LOW = 5'b00100,
        PH_HIGH = 5'b01000,
        PH_GAP = 5'b10000
    } phase_t;

    typedef struct packed {
        logic accepted;
        logic busy_res;
        logic data_line;
        logic clock_line;
    } result_t;

endpackage

FILE: sv/two_wire_audio_command_transmitter.sv
// Channel   Direction  Word
// s_axis    in         tuser: op; tdata: sound_address, volume_level
// m_axis    out        tdata: clock_line, data_line, busy_res, accepted
// cfg       in         cfg_index selects the timing register, cfg_data is its value
//
// Each word in gives one word out; one word is taken every cycle unless the output buffer is full.
// The line state advances in a single registered step per word, and the result
// goes to a two-entry output buffer, so input stalls only when both entries are full.
// Reset restores the timing defaults and leaves both lines high and the block idle.
module two_wire_audio_command_transmitter
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [9:0] sound_address, [13:10] volume_level, [15:14] zero
    input  logic [15:0]                   s_tdata,
    // [2:0] op
    input  logic [2:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] clock_line, [1] data_line, [2] busy_res, [3] accepted, [7:4] zero
    output logic [7:0]                    m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [twa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                   cfg_data
);

    logic step;
    logic take;
    twa_pkg::result_t result;
    twa_pkg::result_t out_reg;
    twa_pkg::result_t skid_reg;
    logic out_valid_reg;
    logic skid_valid_reg;

    assign cfg_ready = 1'b1;
    assign s_tready = !skid_valid_reg;
    assign step = s_tvalid && s_tready;
    assign take = out_valid_reg && m_tready;

    twa_core u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .step          (step),
        .op            (s_tuser),
        .sound_address (s_tdata[9:0]),
        .volume_level  (s_tdata[13:10]),
        .result        (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg && take)
        begin
            skid_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            if (out_valid_reg && !take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg && take)
        begin
            out_reg <= skid_reg;
        end
        else if (step)
        begin
            if (out_valid_reg && !take)
            begin
                skid_reg <= result;
            end
            else
            begin
                out_reg <= result;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {4'd0, out_reg.accepted, out_reg.busy_res, out_reg.data_line,
        out_reg.clock_line};

endmodule

FILE: sv/twa_core.sv
module twa_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [twa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [twa_pkg::TIMER_W-1:0]        cfg_data,
    input  logic                               step,
    input  logic [twa_pkg::OP_W-1:0]           op,
    input  logic [twa_pkg::ADDR_W-1:0]         sound_address,
    input  logic [twa_pkg::VOL_W-1:0]          volume_level,
    output twa_pkg::result_t                   result
);

    logic [twa_pkg::TIMER_W-1:0] start_low_reg;
    logic [twa_pkg::TIMER_W-1:0] half_bit_reg;
    logic [twa_pkg::TIMER_W-1:0] gap_reg;

    logic [31:0] pending_reg, pending_next;
    logic [2:0] bytes_left_reg, bytes_left_next;
    logic [2:0] bit_index_reg, bit_index_next;
    twa_pkg::phase_t phase_reg, phase_next;
    logic [twa_pkg::TIMER_W-1:0] timer_reg, timer_next;
    logic clock_reg, clock_next;
    logic data_reg, data_next;
    logic accepted;

    logic [1:0] byte_sel;
    logic [7:0] cur_byte;
    logic [2:0] low_bit_index;
    logic [2:0] bytes_dec;
    logic is_command;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_low_reg <= twa_pkg::START_LOW_RESET;
            half_bit_reg <= twa_pkg::HALF_BIT_RESET;
            gap_reg <= twa_pkg::GAP_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == twa_pkg::CFG_START_LOW)
            begin
                start_low_reg <= cfg_data;
            end
            else if (cfg_index == twa_pkg::CFG_HALF_BIT)
            begin
                half_bit_reg <= cfg_data;
            end
            else if (cfg_index == twa_pkg::CFG_GAP)
            begin
                gap_reg <= cfg_data;
            end
        end
    end

    assign byte_sel = 2'(bytes_left_reg - 3'd1);
    assign cur_byte = pending_reg[{byte_sel, 3'b000} +: 8];
    assign low_bit_index = (phase_reg == twa_pkg::PH_START) ? 3'd0 : 3'(bit_index_reg + 3'd1);
    assign bytes_dec = (bytes_left_reg != 3'd0) ? 3'(bytes_left_reg - 3'd1) : 3'd0;
    assign is_command = (op == twa_pkg::OP_PLAY) || (op == twa_pkg::OP_PLAY_AFTER)
        || (op == twa_pkg::OP_LOOP) || (op == twa_pkg::OP_STOP)
        || (op == twa_pkg::OP_VOLUME);

    always_comb
    begin
        pending_next = pending_reg;
        bytes_left_next = bytes_left_reg;
        bit_index_next = bit_index_reg;
        phase_next = phase_reg;
        timer_next = timer_reg;
        clock_next = clock_reg;
        data_next = data_reg;
        accepted = 1'b0;

        if (op == twa_pkg::OP_TICK)
        begin
            if (phase_reg != twa_pkg::PH_IDLE)
            begin
                if (timer_reg > 16'd1)
                begin
                    timer_next = timer_reg - 16'd1;
                end
                else
                begin
                    unique case (phase_reg)
                        twa_pkg::PH_START, twa_pkg::PH_LOW, twa_pkg::PH_HIGH:
                        begin
                            if (phase_reg == twa_pkg::PH_LOW)
                            begin
                                phase_next = twa_pkg::PH_HIGH;
                                clock_next = 1'b1;
                                timer_next = half_bit_reg;
                            end
                            else if (phase_reg == twa_pkg::PH_HIGH && bit_index_reg == 3'd7)
                            begin
                                phase_next = twa_pkg::PH_GAP;
                                clock_next = 1'b1;
                                data_next = 1'b1;
                                timer_next = gap_reg;
                            end
                            else
                            begin
                                bit_index_next = low_bit_index;
                                phase_next = twa_pkg::PH_LOW;
                                clock_next = 1'b0;
                                data_next = cur_byte[low_bit_index];
                                timer_next = half_bit_reg;
                            end
                        end
                        twa_pkg::PH_GAP:
                        begin
                            bytes_left_next = bytes_dec;
                            if (bytes_dec != 3'd0)
                            begin
                                phase_next = twa_pkg::PH_START;
                                clock_next = 1'b0;
                                timer_next = start_low_reg;
                            end
                            else
                            begin
                                phase_next = twa_pkg::PH_IDLE;
                                timer_next = '0;
                                pending_next = '0;
                            end
                        end
                        default:
                        begin
                            phase_next = twa_pkg::PH_IDLE;
                            timer_next = '0;
                        end
                    endcase
                end
            end
        end
        else if (is_command && phase_reg == twa_pkg::PH_IDLE)
        begin
            bytes_left_next = 3'd2;
            unique case (op)
                twa_pkg::OP_PLAY:
                begin
                    pending_next = {22'd0, sound_address};
                end
                twa_pkg::OP_PLAY_AFTER:
                begin
                    pending_next = {twa_pkg::WORD_PLAY_AFTER, 6'd0, sound_address};
                    bytes_left_next = 3'd4;
                end
                twa_pkg::OP_LOOP:
                begin
                    pending_next = {16'd0, twa_pkg::WORD_LOOP};
                end
                twa_pkg::OP_STOP:
                begin
                    pending_next = {16'd0, twa_pkg::WORD_STOP};
                end
                default:
                begin
                    pending_next = {16'd0, twa_pkg::WORD_VOLUME + {12'd0, volume_level}};
                end
            endcase
            bit_index_next = 3'd0;
            phase_next = twa_pkg::PH_START;
            clock_next = 1'b0;
            timer_next = start_low_reg;
            accepted = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            bytes_left_reg <= '0;
            bit_index_reg <= '0;
            phase_reg <= twa_pkg::PH_IDLE;
            timer_reg <= '0;
            clock_reg <= 1'b1;
            data_reg <= 1'b1;
        end
        else if (step)
        begin
            pending_reg <= pending_next;
            bytes_left_reg <= bytes_left_next;
            bit_index_reg <= bit_index_next;
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            clock_reg <= clock_next;
            data_reg <= data_next;
        end
    end

    assign result.accepted = accepted;
    assign result.busy_res = (phase_next != twa_pkg::PH_IDLE);
    assign result.data_line = data_next;
    assign result.clock_line = clock_next;

endmodule

FILE: dv/two_wire_audio_command_transmitter_tb.sv
`timescale 1ns / 100ps

module two_wire_audio_command_transmitter_tb;

    import twa_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam result_t LINES_IDLE = 4'b0011;
    localparam result_t LINES_TAKEN = 4'b1110;
    localparam result_t LINES_HELD = 4'b0110;

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int NUM_ROWS = 20;
    localparam int FIRST_FAST_ROW = 3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] addr;
        logic [VOL_W-1:0]  vol;
    } line_item_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] addr;
        logic [VOL_W-1:0]  vol;
        logic              typed;
        result_t           want;
        logic              run_out;
    } line_row_t;

    localparam line_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{OP_TICK,       10'd0,    4'd0,  1'b1, LINES_IDLE,  1'b0},
        '{OP_SPARE_A,    10'h3FF,  4'hF,  1'b1, LINES_IDLE,  1'b0},
        '{OP_SPARE_B,    10'd0,    4'd0,  1'b1, LINES_IDLE,  1'b0},
        '{OP_PLAY,       10'h3FF,  4'hF,  1'b1, LINES_TAKEN, 1'b0},
        '{OP_PLAY_AFTER, 10'd0,    4'd0,  1'b1, LINES_HELD,  1'b0},
        '{OP_SPARE_A,    10'd0,    4'd0,  1'b1, LINES_HELD,  1'b0},
        '{OP_TICK,       10'h3FF,  4'hF,  1'b1, LINES_HELD,  1'b1},
        '{OP_PLAY,       10'd0,    4'd0,  1'b1, LINES_TAKEN, 1'b1},
        '{OP_PLAY,       10'd999,  4'd5,  1'b1, LINES_TAKEN, 1'b1},
        '{OP_PLAY,       10'd1023, 4'd0,  1'b1, LINES_TAKEN, 1'b1},
        '{OP_PLAY_AFTER, 10'h155,  4'hA,  1'b1, LINES_TAKEN, 1'b1},
        '{OP_LOOP,       10'd0,    4'hF,  1'b1, LINES_TAKEN, 1'b1},
        '{OP_STOP,       10'h3FF,  4'd0,  1'b1, LINES_TAKEN, 1'b1},
        '{OP_VOLUME,     10'd0,    4'd0,  1'b1, LINES_TAKEN, 1'b1},
        '{OP_VOLUME,     10'd0,    4'hF,  1'b1, LINES_TAKEN, 1'b0},
        '{OP_TICK,       10'd0,    4'd0,  1'b0, LINES_IDLE,  1'b0},
        '{OP_VOLUME,     10'h2AA,  4'd3,  1'b0, LINES_IDLE,  1'b0},
        '{OP_TICK,       10'h155,  4'hC,  1'b0, LINES_IDLE,  1'b1},
        '{OP_TICK,       10'd0,    4'd0,  1'b1, LINES_IDLE,  1'b0},
        '{OP_STOP,       10'd0,    4'd0,  1'b1, LINES_TAKEN, 1'b1}
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata = '0;
    logic [2:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [7:0]           m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data = '0;

    logic calm = 1'b0;
    logic hold_off = 1'b0;
    logic pressure_armed = 1'b0;
    int   source_gap = 0;
    int   sink_stall = 0;
    int   line_mismatches = 0;
    int   cycle_count = 0;

    line_item_t line_items[$];
    result_t    expected_lines[$];

    logic [TIMER_W-1:0] start_low = START_LOW_RESET;
    logic [TIMER_W-1:0] half_bit = HALF_BIT_RESET;
    logic [TIMER_W-1:0] gap_len = GAP_RESET;
    logic [31:0]        tx_words = '0;
    logic [2:0]         tx_bytes_left = '0;
    logic [3:0]         tx_bit = '0;
    phase_t             tx_phase = PH_IDLE;
    logic [TIMER_W-1:0] tx_timer = '0;
    logic               clk_lvl = 1'b1;
    logic               dat_lvl = 1'b1;

    two_wire_audio_command_transmitter dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int pick_pause();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (roll < 70)
            return 0;
        if (roll < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function void open_byte();
        tx_phase = PH_START;
        clk_lvl = 1'b0;
        tx_timer = start_low;
    endfunction

    function void open_low_half();
        logic [1:0] sel;
        logic [7:0] cur;
        sel = tx_bytes_left[1:0] - 2'd1;
        cur = tx_words[sel*8 +: 8];
        tx_phase = PH_LOW;
        clk_lvl = 1'b0;
        dat_lvl = cur[tx_bit[2:0]];
        tx_timer = half_bit;
    endfunction

    function void spend_tick();
        if (tx_timer > 16'd1)
        begin
            tx_timer = tx_timer - 16'd1;
            return;
        end
        case (tx_phase)
            PH_START:
            begin
                tx_bit = '0;
                open_low_half();
            end
            PH_LOW:
            begin
                tx_phase = PH_HIGH;
                clk_lvl = 1'b1;
                tx_timer = half_bit;
            end
            PH_HIGH:
            begin
                if (tx_bit < 4'd7)
                begin
                    tx_bit = tx_bit + 4'd1;
                    open_low_half();
                end
                else
                begin
                    tx_phase = PH_GAP;
                    clk_lvl = 1'b1;
                    dat_lvl = 1'b1;
                    tx_timer = gap_len;
                end
            end
            PH_GAP:
            begin
                if (tx_bytes_left > 3'd0)
                    tx_bytes_left = tx_bytes_left - 3'd1;
                if (tx_bytes_left > 3'd0)
                    open_byte();
                else
                begin
                    tx_phase = PH_IDLE;
                    tx_timer = '0;
                    tx_words = '0;
                end
            end
            default:
            begin
                tx_phase = PH_IDLE;
                tx_timer = '0;
            end
        endcase
    endfunction

    function result_t predict_lines(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                                    input logic [VOL_W-1:0] vol);
        result_t r;
        logic took;
        took = 1'b0;
        if (op == OP_TICK)
        begin
            if (tx_phase != PH_IDLE)
                spend_tick();
        end
        else if (op <= OP_VOLUME && tx_phase == PH_IDLE)
        begin
            tx_bytes_left = 3'd2;
            case (op)
                OP_PLAY: tx_words = {22'd0, addr};
                OP_PLAY_AFTER:
                begin
                    tx_words = {WORD_PLAY_AFTER, 6'd0, addr};
                    tx_bytes_left = 3'd4;
                end
                OP_LOOP: tx_words = {16'd0, WORD_LOOP};
                OP_STOP: tx_words = {16'd0, WORD_STOP};
                default: tx_words = {16'd0, WORD_VOLUME + {12'd0, vol}};
            endcase
            tx_bit = '0;
            open_byte();
            took = 1'b1;
        end
        r.clock_line = clk_lvl;
        r.data_line = dat_lvl;
        r.busy_res = (tx_phase != PH_IDLE);
        r.accepted = took;
        return r;
    endfunction

    task automatic offer(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                         input logic [VOL_W-1:0] vol, input logic typed, input result_t want);
        result_t predicted;
        line_item_t item;
        while (line_items.size() > 8)
            @(posedge clk);
        predicted = predict_lines(op, addr, vol);
        item.op = op;
        item.addr = addr;
        item.vol = vol;
        line_items.push_back(item);
        expected_lines.push_back(typed ? want : predicted);
    endtask

    task automatic run_out();
        while (tx_phase != PH_IDLE)
            offer(OP_TICK, 10'($urandom_range(0, 1023)), 4'($urandom_range(0, 15)), 1'b0,
                  LINES_IDLE);
    endtask

    task automatic random_items(input int quota);
        int counted;
        int roll;
        logic [OP_W-1:0] op;
        counted = 0;
        while (counted < quota)
        begin
            roll = $urandom_range(0, 99);
            if (tx_phase == PH_IDLE)
            begin
                if (roll < 8)
                    op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
                else if (roll < 16)
                    op = OP_TICK;
                else
                begin
                    op = 3'($urandom_range(OP_PLAY, OP_VOLUME));
                    counted++;
                end
            end
            else if (roll < 4)
                op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
            else
            begin
                op = (roll < 90) ? OP_TICK : 3'($urandom_range(OP_PLAY, OP_VOLUME));
                counted++;
            end
            offer(op, 10'($urandom_range(0, 1023)), 4'($urandom_range(0, 15)), 1'b0, LINES_IDLE);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        @(posedge clk);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_START_LOW: start_low = value;
            CFG_HALF_BIT: half_bit = value;
            CFG_GAP: gap_len = value;
            default: ;
        endcase
    endtask

    task automatic set_timing(input logic [15:0] start_v, input logic [15:0] half_v,
                              input logic [15:0] gap_v);
        write_reg(CFG_START_LOW, start_v);
        write_reg(CFG_HALF_BIT, half_v);
        write_reg(CFG_GAP, gap_v);
    endtask

    task automatic settle();
        while (line_items.size() != 0 || expected_lines.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin : source
        logic offering;
        if (rst_n)
        begin
            offering = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                line_items.delete(0);
                offering = 1'b0;
                source_gap = pick_pause();
            end
            if (!offering)
            begin
                if (source_gap > 0 && !hold_off)
                    source_gap--;
                else if (line_items.size() > 0)
                    offering = 1'b1;
            end
            s_tvalid <= offering;
            if (offering)
            begin
                s_tuser <= line_items[0].op;
                s_tdata <= {2'b00, line_items[0].vol, line_items[0].addr};
            end
        end
    end

    always @(posedge clk)
    begin : sink
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata[3:0]);
                if (expected_lines.size() == 0)
                begin
                    line_mismatches++;
                    if (line_mismatches <= 10)
                        $display("%0t: unexpected word %h", $time, m_tdata);
                end
                else
                begin
                    want = expected_lines.pop_front();
                    if (got !== want || m_tdata[7:4] !== 4'd0)
                    begin
                        line_mismatches++;
                        if (line_mismatches <= 10)
                            $display("%0t: want acc=%b busy=%b data=%b clk=%b, got word %h",
                                     $time, want.accepted, want.busy_res, want.data_line,
                                     want.clock_line, m_tdata);
                    end
                end
            end
            if (hold_off)
                m_tready <= 1'b0;
            else if (sink_stall > 0)
            begin
                sink_stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                sink_stall = pick_pause();
            end
        end
    end

    // The receiver stops for a long stretch so that the output buffer fills and the
    // input side has to stall.
    initial
    begin : backpressure
        wait (pressure_armed);
        repeat (100) @(posedge clk);
        hold_off <= 1'b1;
        repeat (48) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin : regression
        line_row_t row;
        int i;
        int p;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < NUM_ROWS; i++)
        begin
            row = DIRECTED_ROWS[i];
            if (i == FIRST_FAST_ROW)
            begin
                settle();
                set_timing(16'd1, 16'd1, 16'd1);
            end
            offer(row.op, row.addr, row.vol, row.typed, row.want);
            if (row.run_out)
                run_out();
        end

        settle();
        set_timing(16'd2, 16'd1, 16'd3);
        calm <= 1'b1;
        offer(OP_STOP, 10'd0, 4'd0, 1'b1, LINES_TAKEN);
        run_out();

        pressure_armed <= 1'b1;
        for (p = 0; p < 5; p++)
        begin
            settle();
            case (p)
                0: set_timing(16'd0, 16'd0, 16'd0);
                1: set_timing(16'd2, 16'd1, 16'd3);
                2: set_timing(16'($urandom_range(1, 4)), 16'($urandom_range(1, 3)),
                              16'($urandom_range(1, 4)));
                3:
                begin
                    set_timing(16'd1, 16'd2, 16'd1);
                    write_reg(CFG_SPARE, 16'hFFFF);
                end
                default: set_timing(16'($urandom_range(0, 5)), 16'($urandom_range(0, 3)),
                                    16'($urandom_range(0, 5)));
            endcase
            calm <= ($urandom_range(0, 3) == 0);
            random_items(25);
        end

        settle();
        calm <= 1'b0;
        set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
        random_items(15);

        settle();
        repeat (8) @(posedge clk);
        if (line_mismatches == 0 && expected_lines.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
